// ===== hw/rtl/pva_pkg.sv =====
`timescale 1ns / 1ps
package pva_pkg;

   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int MAX_STAGES      = 24;
   localparam int NSTAGE          = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int GUARD_BITS      = 10;

   // one turn is 45 * 2^SH angle codes
   localparam int SH    = 3 + ANGLE_FRAC_BITS;
   localparam int FULL  = 45 << SH;
   localparam int RW    = $clog2(FULL);
   localparam int TW    = 32 - SH;
   localparam int RND   = 22;

   localparam int XW    = 30;
   localparam int VW    = 32;
   localparam int ZW    = 34;

   localparam logic [30:0] INV_GAIN2 = 31'd1583795506;

   localparam logic [31:0] ATAN_TURN [0:24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81, 32'd41
   };

   typedef logic [TW-1:0] frac_tab_type [0:44];

   function automatic frac_tab_type make_frac_tab();
      frac_tab_type tab;
      for (int e = 0; e < 45; e++) begin
         tab[e] = TW'(((64'(e) << TW) + 64'(RND)) / 64'd45);
      end
      return tab;
   endfunction

endpackage

// ===== hw/rtl/polar_vector_add.sv =====
`timescale 1ns / 1ps
// the item passes angle conversion, rotation, then add, vectoring and gain,
//    with one cordic iteration per register stage
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous, active high, clears the valid bits of every stage
module polar_vector_add (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_mag_a,
   input  logic signed [15:0] req_ang_a,
   input  logic [15:0]        req_mag_b,
   input  logic signed [15:0] req_ang_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_sum_mag,
   output logic signed [14:0] rsp_sum_ang,
   output logic               rsp_nonzero
);
   import pva_pkg::*;

   logic                 en;
   logic                 tv_a, tv_b, rv_a, rv_b;
   logic [31:0]          turn_a, turn_b;
   logic [15:0]          mag_a_ff [0:5];
   logic [15:0]          mag_b_ff [0:5];
   logic signed [XW-1:0] xa, ya, xb, yb;

   assign en        = rsp_ready | ~rsp_valid;
   assign req_ready = en;

   // magnitudes wait alongside the angle conversion
   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff[0] <= req_mag_a;
         mag_b_ff[0] <= req_mag_b;
         for (int k = 1; k < 6; k++) begin
            mag_a_ff[k] <= mag_a_ff[k-1];
            mag_b_ff[k] <= mag_b_ff[k-1];
         end
      end
   end

   pva_turn u_turn_a (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid & en),
      .ang(req_ang_a), .out_valid(tv_a), .turn(turn_a)
   );

   pva_turn u_turn_b (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid & en),
      .ang(req_ang_b), .out_valid(tv_b), .turn(turn_b)
   );

   pva_rotate u_rot_a (
      .clock(clock), .reset(reset), .en(en), .in_valid(tv_a),
      .mag(mag_a_ff[5]), .turn(turn_a), .out_valid(rv_a), .x(xa), .y(ya)
   );

   pva_rotate u_rot_b (
      .clock(clock), .reset(reset), .en(en), .in_valid(tv_b),
      .mag(mag_b_ff[5]), .turn(turn_b), .out_valid(rv_b), .x(xb), .y(yb)
   );

   pva_vector u_vec (
      .clock(clock), .reset(reset), .en(en), .in_valid(rv_a),
      .xa(xa), .ya(ya), .xb(xb), .yb(yb),
      .out_valid(rsp_valid), .sum_mag(rsp_sum_mag), .sum_ang(rsp_sum_ang),
      .nonzero(rsp_nonzero)
   );

`ifndef ASSERT_OFF
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (tv_a == tv_b) && (rv_a == rv_b))
      else $error("lane valid bits disagree");

   a_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nonzero == (rsp_sum_mag != 17'd0)))
      else $error("nonzero flag does not match magnitude");

   a_zero_ang: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_nonzero) |-> (rsp_sum_ang == 15'sd0))
      else $error("zero sum with nonzero angle");

   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sum_ang >= -15'sd11520) && (rsp_sum_ang < 15'sd11520))
      else $error("angle out of range");
`endif

endmodule

// ===== hw/rtl/pva_turn.sv =====
`timescale 1ns / 1ps
module pva_turn (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] ang,
   output logic               out_valid,
   output logic [31:0]        turn
);
   import pva_pkg::*;

   localparam int RSA = 24;
   localparam logic [23:0] RA = 24'((64'd1 << RSA) / FULL);
   localparam int OFFM = 32768 % FULL;
   localparam int RSB = RW + 7;
   localparam logic [RSB-1:0] RB = RSB'((64'd1 << RSB) / 45);
   localparam frac_tab_type FRAC_TAB = make_frac_tab();

   logic [5:0]          v_ff, v_in;
   logic [15:0]         aoff_ff;
   logic [39:0]         pa_ff;
   logic [RW-1:0]       ra_ff, ra_in;
   logic [RW-1:0]       r_ff, r_in;
   logic [RW-1:0]       rb_ff;
   logic [RW+RSB-1:0]   pb_ff;
   logic [SH-1:0]       q_ff, q_in;
   logic [5:0]          e_ff, e_in;
   logic [31:0]         turn_ff;

   logic [15:0]         aoff;
   logic [15:0]         qa;
   logic [31:0]         ra_w;
   logic [RW:0]         r_w;
   logic [SH-1:0]       q0;
   logic [RW-1:0]       e0;

   always_comb begin
      v_in  = {v_ff[4:0], in_valid};
      aoff  = ang ^ 16'h8000;
      qa    = pa_ff[RSA +: 16];
      ra_w  = 32'(aoff_ff) - 32'(32'(qa) * 32'(FULL));
      ra_in = (ra_w >= 32'(FULL)) ? RW'(ra_w - 32'(FULL)) : RW'(ra_w);
      r_w   = (ra_ff >= RW'(OFFM)) ? ((RW+1)'(ra_ff) - (RW+1)'(OFFM))
                                   : ((RW+1)'(ra_ff) + (RW+1)'(FULL - OFFM));
      r_in  = RW'(r_w);
      q0    = pb_ff[RSB +: SH];
      e0    = rb_ff - RW'(RW'(q0) * RW'(45));
      if (e0 >= RW'(45)) begin
         q_in = q0 + SH'(1);
         e_in = 6'(e0 - RW'(45));
      end else begin
         q_in = q0;
         e_in = 6'(e0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aoff_ff <= aoff;
         pa_ff   <= 40'(aoff) * 40'(RA);
         ra_ff   <= ra_in;
         r_ff    <= r_in;
         rb_ff   <= r_ff;
         pb_ff   <= (RW+RSB)'(r_ff) * (RW+RSB)'(RB);
         q_ff    <= q_in;
         e_ff    <= e_in;
         turn_ff <= {q_ff, FRAC_TAB[e_ff]};
      end
   end

   assign out_valid = v_ff[5];
   assign turn      = turn_ff;

endmodule

// ===== hw/rtl/pva_rotate.sv =====
`timescale 1ns / 1ps
module pva_rotate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [15:0]                   mag,
   input  logic [31:0]                   turn,
   output logic                          out_valid,
   output logic signed [pva_pkg::XW-1:0] x,
   output logic signed [pva_pkg::XW-1:0] y
);
   import pva_pkg::*;

   logic [NSTAGE:0]        v_ff;
   logic signed [XW-1:0]   x_ff [0:NSTAGE];
   logic signed [XW-1:0]   y_ff [0:NSTAGE];
   logic signed [ZW-1:0]   z_ff [0:NSTAGE];

   logic signed [XW-1:0]   m;
   logic signed [ZW-1:0]   z;
   logic signed [XW-1:0]   x0_in;
   logic signed [ZW-1:0]   z0_in;

   always_comb begin
      m = XW'({mag, {GUARD_BITS{1'b0}}});
      z = ZW'(signed'(turn));
      if (z > ZW'(64'sd1073741824)) begin
         x0_in = -m;
         z0_in = z - ZW'(64'sd2147483648);
      end else if (z < -ZW'(64'sd1073741824)) begin
         x0_in = -m;
         z0_in = z + ZW'(64'sd2147483648);
      end else begin
         x0_in = m;
         z0_in = z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTAGE-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= '0;
         z_ff[0] <= z0_in;
      end
   end

   for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
      logic signed [XW-1:0] dx, dy;
      logic signed [ZW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = ZW'(ATAN_TURN[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   assign out_valid = v_ff[NSTAGE];
   assign x         = x_ff[NSTAGE];
   assign y         = y_ff[NSTAGE];

endmodule

// ===== hw/rtl/pva_vector.sv =====
`timescale 1ns / 1ps
module pva_vector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [pva_pkg::XW-1:0] xa,
   input  logic signed [pva_pkg::XW-1:0] ya,
   input  logic signed [pva_pkg::XW-1:0] xb,
   input  logic signed [pva_pkg::XW-1:0] yb,
   output logic                          out_valid,
   output logic [16:0]                   sum_mag,
   output logic signed [14:0]            sum_ang,
   output logic                          nonzero
);
   import pva_pkg::*;

   localparam int PW = 32 + RW + 1;
   localparam int AW = RW + 2;

   logic [NSTAGE+3:0]      v_ff;
   logic signed [VW-1:0]   sx_ff, sy_ff;
   logic signed [VW-1:0]   x_ff [0:NSTAGE];
   logic signed [VW-1:0]   y_ff [0:NSTAGE];
   logic signed [ZW-1:0]   z_ff [0:NSTAGE];
   logic [61:0]            pm_ff;
   logic signed [PW-1:0]   pa_ff;
   logic [16:0]            mag_ff, mag_in;
   logic signed [14:0]     ang_ff, ang_in;
   logic                   nz_ff, nz_in;

   logic [VW-2:0]          xc;
   logic signed [31:0]     s;
   logic [62:0]            pm_r;
   logic [20:0]            mag_w;
   logic signed [PW-1:0]   pa_r;
   logic signed [AW-1:0]   ang_w;
   logic signed [AW-1:0]   ang_n;

   always_comb begin
      xc     = (x_ff[NSTAGE] < 0) ? '0 : x_ff[NSTAGE][VW-2:0];
      s      = signed'(z_ff[NSTAGE][31:0]);
      pm_r   = 63'(pm_ff) + (63'd1 << 41);
      mag_w  = pm_r[62:42];
      pa_r   = pa_ff + PW'(64'sd2147483648);
      ang_w  = AW'(pa_r >>> 32);
      ang_n  = (ang_w >= AW'(FULL / 2)) ? (ang_w - AW'(FULL)) : ang_w;
      mag_in = (mag_w > 21'd131071) ? 17'd131071 : mag_w[16:0];
      nz_in  = (mag_in != '0);
      ang_in = nz_in ? 15'(ang_n) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTAGE+2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= VW'(xa) + VW'(xb);
         sy_ff <= VW'(ya) + VW'(yb);
         if (sx_ff < 0) begin
            x_ff[0] <= -sx_ff;
            y_ff[0] <= -sy_ff;
            z_ff[0] <= ZW'(64'sd2147483648);
         end else begin
            x_ff[0] <= sx_ff;
            y_ff[0] <= sy_ff;
            z_ff[0] <= '0;
         end
         pm_ff  <= 62'(xc) * 62'(INV_GAIN2);
         pa_ff  <= PW'(s) * PW'(FULL);
         mag_ff <= mag_in;
         ang_ff <= ang_in;
         nz_ff  <= nz_in;
      end
   end

   for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
      logic signed [VW-1:0] dx, dy;
      logic signed [ZW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = ZW'(ATAN_TURN[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end
         end
      end
   end

   assign out_valid = v_ff[NSTAGE+3];
   assign sum_mag   = mag_ff;
   assign sum_ang   = ang_ff;
   assign nonzero   = nz_ff;

endmodule

// ===== tb/polar_vector_add_test.sv =====
`timescale 1ns / 1ps
module polar_vector_add_test;
   import pva_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic [16:0]        mag;
      logic signed [14:0] ang;
      logic               nz;
   } vsum_type;

   class sum_board;
      vsum_type pending[$];
      int       errors;

      static function automatic longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function automatic logic [31:0] to_turn(logic signed [15:0] raw);
         longint a, full, r;
         logic [63:0] t;
         a = raw;
         full = 360 <<< ANGLE_FRAC_BITS;
         r = a % full;
         if (r < 0) r += full;
         t = ((64'(r) << 32) + 64'(full / 2)) / 64'(full);
         return t[31:0];
      endfunction

      static function automatic void rotate(logic [15:0] mag, logic [31:0] turn,
                                            output longint xo, output longint yo);
         longint m, z, x, y, dx, dy;
         m = longint'(mag) <<< GUARD_BITS;
         z = turn[31] ? longint'(turn) - 64'sd4294967296 : longint'(turn);
         x = m; y = 0;
         if (z > 64'sd1073741824) begin
            x = -m; z -= 64'sd2147483648;
         end else if (z < -64'sd1073741824) begin
            x = -m; z += 64'sd2147483648;
         end
         for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shift(y, i); dy = floor_shift(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
               x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
         end
         xo = x; yo = y;
      endfunction

      function void note_input(logic [15:0] ma, logic signed [15:0] aa,
                               logic [15:0] mb, logic signed [15:0] ab);
         longint xa, ya, xb, yb, x, y, z, dx, dy, s, full, ang;
         logic [63:0] prod;
         logic [31:0] u;
         vsum_type r;
         rotate(ma, to_turn(aa), xa, ya);
         rotate(mb, to_turn(ab), xb, yb);
         x = xa + xb; y = ya + yb; z = 0;
         if (x < 0) begin
            x = -x; y = -y; z = 64'sd2147483648;
         end
         for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shift(y, i); dy = floor_shift(x, i);
            if (y >= 0) begin
               x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end else begin
               x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end
         end
         if (x < 0) x = 0;
         prod = (64'(x) * 64'(INV_GAIN2) + (64'd1 << (31 + GUARD_BITS))) >> (32 + GUARD_BITS);
         if (prod > 64'd131071) prod = 64'd131071;
         r.mag = prod[16:0];
         if (prod == 0) begin
            r.nz = 1'b0; r.ang = '0;
         end else begin
            u = z[31:0];
            s = u[31] ? longint'(u) - 64'sd4294967296 : longint'(u);
            full = 360 <<< ANGLE_FRAC_BITS;
            ang = floor_shift(s * full + 64'sd2147483648, 32);
            if (ang >= full / 2) ang -= full;
            r.nz = 1'b1; r.ang = ang[14:0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [16:0] mag, logic signed [14:0] ang, logic nz);
         vsum_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item mag=%0d ang=%0d nz=%0d", $time, mag, ang, nz);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (mag !== e.mag) begin
            $display("%0t: sum_mag expected %0d actual %0d", $time, e.mag, mag);
            errors++;
         end
         if (ang !== e.ang) begin
            $display("%0t: sum_ang expected %0d actual %0d", $time, e.ang, ang);
            errors++;
         end
         if (nz !== e.nz) begin
            $display("%0t: nonzero expected %0d actual %0d", $time, e.nz, nz);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_nonzero;
   logic [15:0] req_mag_a, req_mag_b;
   logic signed [15:0] req_ang_a, req_ang_b;
   logic [16:0] rsp_sum_mag;
   logic signed [14:0] rsp_sum_ang;

   sum_board board;
   int idle_count;
   bit stall_mode;

   polar_vector_add i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1; req_valid = 1'b0; rsp_ready = 1'b0;
      req_mag_a = '0; req_ang_a = '0; req_mag_b = '0; req_ang_b = '0;
   end

   // receiver stall pattern, switched between busy and free stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_sum_mag, rsp_sum_ang, rsp_nonzero);
      if (!reset && req_valid && req_ready)
         board.note_input(req_mag_a, req_ang_a, req_mag_b, req_ang_b);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_pair(logic [15:0] ma, logic [15:0] aa, logic [15:0] mb,
                            logic [15:0] ab);
      req_valid <= 1'b1;
      req_mag_a <= ma; req_ang_a <= aa; req_mag_b <= mb; req_ang_b <= ab;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_mag();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 3));
         1: return 16'hffff - 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int burst, sent, wait_cycles;
      logic [15:0] m, a;
      board = new();
      stall_mode = 1'b0;
      idle_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_pair(16'hffff, 16'h0000, 16'hffff, 16'h0000);
      send_pair(16'hffff, 16'h7fff, 16'hffff, 16'h8000);
      send_pair(16'h1234, 16'h0000, 16'h1234, 16'd11520);
      send_pair(16'h1000, 16'd11520, 16'h0000, 16'h0000);
      send_pair(16'h1000, 16'hd300, 16'h0800, 16'd5760);
      send_pair(16'h0001, 16'd5760, 16'h0001, 16'he9a0);
      send_pair(16'h0001, 16'd0, 16'h0000, 16'd0);
      send_pair(16'hffff, 16'd23040, 16'h0000, 16'd0);
      send_pair(16'h8000, 16'd11519, 16'h8000, 16'd11521);
      send_pair(16'h4000, 16'd5761, 16'h4000, 16'hd2ff);
      send_pair(16'h0000, 16'h8000, 16'hffff, 16'h7fff);
      send_pair(16'h0100, 16'd1, 16'h0100, 16'hffff);
      send_gap();

      sent = 0;
      while (sent < 400) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            m = pick_mag();
            a = 16'($urandom);
            if ($urandom_range(0, 4) == 0)
               // opposite vectors to hit small or zero sums
               send_pair(m, a, m + 16'($urandom_range(0, 2)),
                         16'(int'($signed(a)) + 11520 + int'($urandom_range(0, 2)) - 1));
            else
               send_pair(m, a, pick_mag(), 16'($urandom));
            sent++;
         end
         send_gap();
      end

      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
